### rtl/uwc_pkg.sv
// ----------------------------------------------------------------------------
// uwc_pkg
// Shared types, constants and helper functions for the UTF-8 word counter.
// ----------------------------------------------------------------------------
package uwc_pkg;

  // Width of the internal word tally and of the reported total
  localparam int COUNT_BITS = 23;
  localparam int TOTAL_BITS = 23;
  localparam int POINT_BITS = 21;

  // Sequence length codes
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // Code point limits
  localparam logic [POINT_BITS-1:0] CP_MAX        = 21'h10FFFF;
  localparam logic [POINT_BITS-1:0] CP_SURR_LO    = 21'h00D800;
  localparam logic [POINT_BITS-1:0] CP_SURR_HI    = 21'h00DFFF;
  localparam logic [POINT_BITS-1:0] CP_APOS       = 21'h000027;
  localparam logic [POINT_BITS-1:0] CP_RSQUO      = 21'h002019;
  localparam logic [POINT_BITS-1:0] CP_MIN_TWO    = 21'h000080;
  localparam logic [POINT_BITS-1:0] CP_MIN_THREE  = 21'h000800;
  localparam logic [POINT_BITS-1:0] CP_MIN_FOUR   = 21'h010000;
  localparam logic [POINT_BITS-1:0] CP_LATIN_LO   = 21'h0000C0;
  localparam logic [POINT_BITS-1:0] CP_LATIN_HI   = 21'h0002AF;
  localparam logic [POINT_BITS-1:0] CP_GRCYR_LO   = 21'h000370;
  localparam logic [POINT_BITS-1:0] CP_GRCYR_HI   = 21'h00052F;
  localparam logic [POINT_BITS-1:0] CP_CJK_LO     = 21'h004E00;
  localparam logic [POINT_BITS-1:0] CP_CJK_HI     = 21'h009FFF;

  // Decoder state carried from byte to byte
  typedef struct packed {
    logic                  in_word;
    logic [POINT_BITS-1:0] partial_point;
    logic [1:0]            bytes_pending;
    logic [2:0]            sequence_length;
    logic [COUNT_BITS-1:0] word_tally;
    logic                  all_valid;
  } uwc_state_t;

  localparam uwc_state_t STATE_RESET = '{
    in_word:         1'b0,
    partial_point:   '0,
    bytes_pending:   2'd0,
    sequence_length: LEN_NONE,
    word_tally:      '0,
    all_valid:       1'b1
  };

  // True for code points that open a word
  function automatic logic is_word_start(input logic [POINT_BITS-1:0] cp);
    logic lower;
    logic upper;
    logic digit;
    lower = (cp >= 21'h61) && (cp <= 21'h7A);
    upper = (cp >= 21'h41) && (cp <= 21'h5A);
    digit = (cp >= 21'h30) && (cp <= 21'h39);
    return lower || upper || digit ||
           ((cp >= CP_LATIN_LO) && (cp <= CP_LATIN_HI)) ||
           ((cp >= CP_GRCYR_LO) && (cp <= CP_GRCYR_HI)) ||
           ((cp >= CP_CJK_LO) && (cp <= CP_CJK_HI));
  endfunction

  // Smallest legal code point for a given sequence length
  function automatic logic [POINT_BITS-1:0] min_point(input logic [2:0] len);
    logic [POINT_BITS-1:0] m;
    unique case (len)
      LEN_TWO:   m = CP_MIN_TWO;
      LEN_THREE: m = CP_MIN_THREE;
      LEN_FOUR:  m = CP_MIN_FOUR;
      default:   m = '0;
    endcase
    return m;
  endfunction

endpackage

### rtl/uwc_decode.sv
// ----------------------------------------------------------------------------
// uwc_decode
// Next-state logic for one text byte: UTF-8 decode, range checks and
// word boundary tracking.
// ----------------------------------------------------------------------------
module uwc_decode import uwc_pkg::*; (
  input  uwc_state_t state,
  input  logic [7:0] data_byte,
  output uwc_state_t state_next
);

  logic                  cont;
  logic                  pending;
  logic                  bad_cont;
  logic                  use_lead;
  logic                  lead_ascii;
  logic                  lead_two;
  logic                  lead_three;
  logic                  lead_four;
  logic                  in_word_eff;
  logic [POINT_BITS-1:0] point_shift;
  logic                  finish;
  logic [POINT_BITS-1:0] cp;
  logic [2:0]            len;
  logic                  range_bad;
  logic                  is_apos;
  logic                  word_char;
  logic                  tally_full;

  // Classify the byte
  assign cont       = (data_byte[7:6] == 2'b10);
  assign pending    = (state.bytes_pending != 2'd0);
  assign bad_cont   = pending && !cont;
  assign use_lead   = !pending || !cont;
  assign lead_ascii = (data_byte[7] == 1'b0);
  assign lead_two   = (data_byte[7:5] == 3'b110);
  assign lead_three = (data_byte[7:4] == 4'b1110);
  assign lead_four  = (data_byte[7:3] == 5'b11110);

  // A broken sequence closes the open word before the byte is retaken
  assign in_word_eff = bad_cont ? 1'b0 : state.in_word;
  assign point_shift = {state.partial_point[POINT_BITS-7:0], data_byte[5:0]};

  // Select the completed code point, if any
  assign finish = use_lead ? lead_ascii : (state.bytes_pending == 2'd1);
  assign cp     = use_lead ? {{(POINT_BITS-7){1'b0}}, data_byte[6:0]} : point_shift;
  assign len    = use_lead ? LEN_ONE : state.sequence_length;

  // Check and classify the completed code point
  assign range_bad  = (cp < min_point(len)) || (cp > CP_MAX) ||
                      ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
  assign is_apos    = (cp == CP_APOS) || (cp == CP_RSQUO);
  assign word_char  = is_word_start(cp) || (is_apos && in_word_eff);
  assign tally_full = &state.word_tally;

  // Build next state
  always_comb begin
    state_next           = state;
    state_next.in_word   = in_word_eff;
    state_next.all_valid = state.all_valid && !bad_cont;
    if (finish) begin
      state_next.partial_point   = '0;
      state_next.bytes_pending   = 2'd0;
      state_next.sequence_length = LEN_NONE;
      if (range_bad) begin
        state_next.in_word   = 1'b0;
        state_next.all_valid = 1'b0;
      end else begin
        if (word_char && !in_word_eff && !tally_full) begin
          state_next.word_tally = state.word_tally + 1'b1;
        end
        state_next.in_word = word_char;
      end
    end else if (!use_lead) begin
      // advance a multi-byte sequence
      state_next.partial_point = point_shift;
      state_next.bytes_pending = state.bytes_pending - 2'd1;
    end else if (lead_two) begin
      state_next.partial_point   = {{(POINT_BITS-5){1'b0}}, data_byte[4:0]};
      state_next.sequence_length = LEN_TWO;
      state_next.bytes_pending   = 2'd1;
    end else if (lead_three) begin
      state_next.partial_point   = {{(POINT_BITS-4){1'b0}}, data_byte[3:0]};
      state_next.sequence_length = LEN_THREE;
      state_next.bytes_pending   = 2'd2;
    end else if (lead_four) begin
      state_next.partial_point   = {{(POINT_BITS-3){1'b0}}, data_byte[2:0]};
      state_next.sequence_length = LEN_FOUR;
      state_next.bytes_pending   = 2'd3;
    end else begin
      // drop an illegal lead byte
      state_next.in_word         = 1'b0;
      state_next.all_valid       = 1'b0;
      state_next.partial_point   = '0;
      state_next.bytes_pending   = 2'd0;
      state_next.sequence_length = LEN_NONE;
    end
  end

endmodule

### rtl/uwc_out_buf.sv
// ----------------------------------------------------------------------------
// uwc_out_buf
// Output register with one skid entry, so the input side keeps moving
// while a finished result waits at the output.
// ----------------------------------------------------------------------------
module uwc_out_buf import uwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  res_valid,
  input  logic [TOTAL_BITS-1:0] res_total,
  input  logic                  res_text_valid,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TOTAL_BITS-1:0] word_total,
  output logic                  text_valid
);

  logic                  skid_valid;
  logic [TOTAL_BITS-1:0] skid_total;
  logic                  skid_text_valid;
  logic                  out_free;

  assign out_free = !out_valid || !out_stall;
  assign full     = skid_valid;

  // Control: move skid into output, or park a new result in the skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        word_total <= skid_total;
        text_valid <= skid_text_valid;
      end else if (res_valid) begin
        word_total <= res_total;
        text_valid <= res_text_valid;
      end
    end else if (res_valid) begin
      skid_total      <= res_total;
      skid_text_valid <= res_text_valid;
    end
  end

endmodule

### rtl/utf8_word_counter_core.sv
// ----------------------------------------------------------------------------
// utf8_word_counter_core
// Streaming UTF-8 validator and word counter, one byte per cycle while in_stall is low.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one text byte per transaction in
//   data_byte; last_byte marks the final byte of a text.
//   Output channel (out_valid / out_stall): one transaction per text, with
//   word_total (saturating word count) and text_valid (whole text was
//   well-formed UTF-8, no truncated sequence at the end).
//   Throughput: one byte per cycle while in_stall is low; the decoder state update is a single
//   combinational step between the state register and itself.
//   Result: formed from the last accepted byte and registered in the output
//   register, or parked in the skid entry while the output is stalled.
//   Stall: the output register plus one skid entry hold two results; the
//   input keeps accepting bytes while results wait and raises in_stall only
//   when the skid entry is occupied.
//   Reset: decoder state returns to the empty text, the output is empty.
//   After each last byte the decoder state also returns to the empty text.
// ----------------------------------------------------------------------------
module utf8_word_counter_core import uwc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  last_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TOTAL_BITS-1:0] word_total,
  output logic                  text_valid
);

  uwc_state_t            state;
  uwc_state_t            state_next;
  logic                  accept;
  logic                  buf_full;
  logic                  res_valid;
  logic [TOTAL_BITS-1:0] res_total;
  logic                  res_text_valid;

  assign in_stall = buf_full;
  assign accept   = in_valid && !in_stall;

  uwc_decode u_decode (
    .state      (state),
    .data_byte  (data_byte),
    .state_next (state_next)
  );

  // Form the result on the last byte
  assign res_valid      = accept && last_byte;
  assign res_total      = TOTAL_BITS'({{TOTAL_BITS{1'b0}}, state_next.word_tally});
  assign res_text_valid = state_next.all_valid && (state_next.bytes_pending == 2'd0);

  // Advance decoder state; restart after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (accept) begin
      state <= last_byte ? STATE_RESET : state_next;
    end
  end

  uwc_out_buf u_out_buf (
    .clk            (clk),
    .rst            (rst),
    .res_valid      (res_valid),
    .res_total      (res_total),
    .res_text_valid (res_text_valid),
    .full           (buf_full),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .word_total     (word_total),
    .text_valid     (text_valid)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for utf8_word_counter_core: streams texts of mixed
// well-formed and broken UTF-8 through the byte channel under random idle
// and stall bursts, and compares each per-text word count and validity flag
// against an in-bench decoder.
// ----------------------------------------------------------------------------
module tb import uwc_pkg::*; ();

  localparam int TAIL_BYTES   = 150;   // final stretch runs with no idling
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_BYTES = 1900;

  // One byte transaction as queued for the driver
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       hold;   // wait for all outstanding results before sending
  } text_byte_t;

  // One expected per-text result
  typedef struct packed {
    logic [TOTAL_BITS-1:0] total;
    logic                  ok;
  } text_result_t;

  // Decoder state mirrored by the bench
  typedef struct packed {
    logic                  in_word;
    logic [POINT_BITS-1:0] part;
    logic [1:0]            pending;
    logic [2:0]            seq_len;
    logic [COUNT_BITS-1:0] tally;
    logic                  all_ok;
  } decoder_t;

  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte  = 8'd0;
  logic                  last_byte  = 1'b0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [TOTAL_BITS-1:0] word_total;
  logic                  text_valid;

  text_byte_t   byte_q[$];
  text_result_t word_counts_q[$];
  text_byte_t   drv_item;
  text_result_t mon_want;
  decoder_t     dec;

  int errors         = 0;
  int bytes_total    = 0;
  int bytes_accepted = 0;
  int gap_left       = 0;
  int stall_left     = 0;
  int src_idle_pct   = 0;
  int snk_idle_pct   = 0;
  int mon_cycles     = 0;

  utf8_word_counter_core u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_total (word_total),
    .text_valid (text_valid)
  );

  always #4 clk = ~clk;

  // --------------------------------------------------------------------------
  // Decoder prediction
  // --------------------------------------------------------------------------
  function automatic void clear_sequence();
    dec.pending = 2'd0;
    dec.seq_len = LEN_NONE;
    dec.part    = '0;
  endfunction

  function automatic void reject_sequence();
    clear_sequence();
    dec.in_word = 1'b0;
    dec.all_ok  = 1'b0;
  endfunction

  function automatic void clear_text();
    clear_sequence();
    dec.in_word = 1'b0;
    dec.tally   = '0;
    dec.all_ok  = 1'b1;
  endfunction

  function automatic logic opens_word(input logic [POINT_BITS-1:0] cp);
    return (cp >= 21'h61 && cp <= 21'h7A) || (cp >= 21'h41 && cp <= 21'h5A) ||
           (cp >= 21'h30 && cp <= 21'h39) ||
           (cp >= CP_LATIN_LO && cp <= CP_LATIN_HI) ||
           (cp >= CP_GRCYR_LO && cp <= CP_GRCYR_HI) ||
           (cp >= CP_CJK_LO && cp <= CP_CJK_HI);
  endfunction

  // Check a complete code point and update the word tracking
  function automatic void close_point(input logic [POINT_BITS-1:0] cp,
                                      input logic [2:0] len);
    logic [POINT_BITS-1:0] floor_cp;
    logic                  joins;
    case (len)
      LEN_TWO:   floor_cp = CP_MIN_TWO;
      LEN_THREE: floor_cp = CP_MIN_THREE;
      LEN_FOUR:  floor_cp = CP_MIN_FOUR;
      default:   floor_cp = '0;
    endcase
    clear_sequence();
    if (cp < floor_cp || cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
      reject_sequence();
    end else begin
      joins = opens_word(cp) || ((cp == CP_APOS || cp == CP_RSQUO) && dec.in_word);
      if (joins && !dec.in_word && dec.tally != '1) dec.tally = dec.tally + 1'b1;
      dec.in_word = joins;
    end
  endfunction

  function automatic void take_lead(input logic [7:0] b);
    if (!b[7]) begin
      close_point(POINT_BITS'(b), LEN_ONE);
    end else if (b[7:5] == 3'b110) begin
      dec.part = POINT_BITS'(b[4:0]);
      dec.seq_len = LEN_TWO;
      dec.pending = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      dec.part = POINT_BITS'(b[3:0]);
      dec.seq_len = LEN_THREE;
      dec.pending = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      dec.part = POINT_BITS'(b[2:0]);
      dec.seq_len = LEN_FOUR;
      dec.pending = 2'd3;
    end else begin
      reject_sequence();
    end
  endfunction

  // Advance the decoder by one byte; queue the text result on the last byte
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    text_result_t r;
    if (dec.pending != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        dec.part = {dec.part[POINT_BITS-7:0], b[5:0]};
        dec.pending = dec.pending - 2'd1;
        if (dec.pending == 2'd0) close_point(dec.part, dec.seq_len);
      end else begin
        reject_sequence();
        take_lead(b);
      end
    end else begin
      take_lead(b);
    end
    if (last) begin
      if (dec.pending != 2'd0) reject_sequence();
      r.total = TOTAL_BITS'(dec.tally);
      r.ok = dec.all_ok;
      word_counts_q.insert(word_counts_q.size(), r);
      clear_text();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus construction
  // --------------------------------------------------------------------------
  function automatic void put(input logic [7:0] b);
    text_byte_t t;
    t.data = b;
    t.last = 1'b0;
    t.hold = 1'b0;
    byte_q.insert(byte_q.size(), t);
  endfunction

  function automatic void put_cont(input logic [5:0] v);
    put({2'b10, v});
  endfunction

  // Mark the newest byte as the end of its text
  function automatic void end_text();
    text_byte_t t;
    t = byte_q.pop_back();
    t.last = 1'b1;
    byte_q.insert(byte_q.size(), t);
  endfunction

  // Encode a value with a forced length (allows overlong and out-of-range forms)
  function automatic void put_encoded(input logic [POINT_BITS-1:0] cp,
                                      input logic [2:0] len);
    case (len)
      LEN_ONE: put(cp[7:0]);
      LEN_TWO: begin
        put({3'b110, cp[10:6]});
        put_cont(cp[5:0]);
      end
      LEN_THREE: begin
        put({4'b1110, cp[15:12]});
        put_cont(cp[11:6]);
        put_cont(cp[5:0]);
      end
      default: begin
        put({5'b11110, cp[20:18]});
        put_cont(cp[17:12]);
        put_cont(cp[11:6]);
        put_cont(cp[5:0]);
      end
    endcase
  endfunction

  function automatic void put_point(input logic [POINT_BITS-1:0] cp);
    if (cp < 21'h80)         put_encoded(cp, LEN_ONE);
    else if (cp < 21'h800)   put_encoded(cp, LEN_TWO);
    else if (cp < 21'h10000) put_encoded(cp, LEN_THREE);
    else                     put_encoded(cp, LEN_FOUR);
  endfunction

  // Lead byte followed by too few continuation bytes
  function automatic void put_partial();
    int n;
    n = $urandom_range(2, 4);
    case (n)
      2:       put({3'b110, 5'($urandom)});
      3:       put({4'b1110, 4'($urandom)});
      default: put({5'b11110, 3'($urandom)});
    endcase
    repeat ($urandom_range(0, n - 2)) put_cont(6'($urandom));
  endfunction

  function automatic logic [POINT_BITS-1:0] border_point();
    logic [POINT_BITS-1:0] cp;
    case ($urandom_range(0, 32))
      0:  cp = 21'h2F;     1:  cp = 21'h30;     2:  cp = 21'h39;
      3:  cp = 21'h3A;     4:  cp = 21'h40;     5:  cp = 21'h41;
      6:  cp = 21'h5A;     7:  cp = 21'h5B;     8:  cp = 21'h60;
      9:  cp = 21'h61;     10: cp = 21'h7A;     11: cp = 21'h7B;
      12: cp = 21'h7F;     13: cp = 21'h80;     14: cp = 21'hBF;
      15: cp = 21'hC0;     16: cp = 21'h2AF;    17: cp = 21'h2B0;
      18: cp = 21'h36F;    19: cp = 21'h370;    20: cp = 21'h52F;
      21: cp = 21'h530;    22: cp = 21'h7FF;    23: cp = 21'h800;
      24: cp = 21'h4DFF;   25: cp = 21'h4E00;   26: cp = 21'h9FFF;
      27: cp = 21'hA000;   28: cp = 21'hD7FF;   29: cp = 21'hE000;
      30: cp = 21'hFFFF;   31: cp = 21'h10000;
      default: cp = CP_MAX;
    endcase
    return cp;
  endfunction

  function automatic logic [POINT_BITS-1:0] rand_point();
    logic [POINT_BITS-1:0] cp;
    case ($urandom_range(0, 13))
      0, 1: begin
        case ($urandom_range(0, 2))
          0:       cp = POINT_BITS'($urandom_range(21'h61, 21'h7A));
          1:       cp = POINT_BITS'($urandom_range(21'h41, 21'h5A));
          default: cp = POINT_BITS'($urandom_range(21'h30, 21'h39));
        endcase
      end
      2:  cp = POINT_BITS'($urandom_range(0, 21'h7F));
      3:  cp = CP_APOS;
      4:  cp = CP_RSQUO;
      5:  cp = POINT_BITS'($urandom_range(CP_LATIN_LO, CP_LATIN_HI));
      6:  cp = POINT_BITS'($urandom_range(21'h80, 21'h7FF));
      7:  cp = POINT_BITS'($urandom_range(CP_GRCYR_LO, CP_GRCYR_HI));
      8:  cp = POINT_BITS'($urandom_range(CP_CJK_LO, CP_CJK_HI));
      9: begin
        // shift surrogates up into the private use block
        cp = POINT_BITS'($urandom_range(21'h800, 21'hFFFF));
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp + 21'h800;
      end
      10: cp = POINT_BITS'($urandom_range(21'h10000, CP_MAX));
      11, 12: cp = 21'h20;
      default: cp = border_point();
    endcase
    return cp;
  endfunction

  function automatic void put_fault();
    logic [7:0] b;
    case ($urandom_range(0, 8))
      0: put(8'($urandom));
      1: put(8'($urandom_range(8'h80, 8'hBF)));
      2: put(8'($urandom_range(8'hF8, 8'hFF)));
      3: put_encoded(POINT_BITS'($urandom_range(0, 21'h7F)), LEN_TWO);
      4: put_encoded(POINT_BITS'($urandom_range(0, 21'h7FF)), LEN_THREE);
      5: put_encoded(POINT_BITS'($urandom_range(0, 21'hFFFF)), LEN_FOUR);
      6: put_encoded(POINT_BITS'($urandom_range(CP_SURR_LO, CP_SURR_HI)), LEN_THREE);
      7: put_encoded(POINT_BITS'($urandom_range(21'h110000, 21'h1FFFFF)), LEN_FOUR);
      default: begin
        // cut a sequence short with a byte that is not a continuation
        put_partial();
        b = 8'($urandom);
        if (b[7:6] == 2'b10) b[6] = 1'b1;
        put(b);
      end
    endcase
  endfunction

  function automatic void add_text(input int n_points, input int fault_pct,
                                   input logic hold);
    int         first;
    text_byte_t t;
    first = byte_q.size();
    repeat (n_points) begin
      if ($urandom_range(0, 99) < fault_pct) put_fault();
      else put_point(rand_point());
    end
    if ($urandom_range(0, 99) < 8) put_partial();
    end_text();
    if (hold) begin
      t = byte_q[first];
      t.hold = 1'b1;
      byte_q[first] = t;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: feed byte transactions from the pending queue
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(drv_item.data, drv_item.last);
        bytes_accepted++;
        if (bytes_accepted % 128 == 0) begin
          case ($urandom_range(0, 3))
            0:       src_idle_pct = 0;
            1:       src_idle_pct = 5;
            2:       src_idle_pct = 20;
            default: src_idle_pct = 50;
          endcase
        end
      end
      // pick the next transaction once the current one is gone
      if (!in_valid || !in_stall) begin
        if (gap_left == 0 && byte_q.size() >= TAIL_BYTES &&
            $urandom_range(0, 99) < src_idle_pct)
          gap_left = $urandom_range(1, 19);
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (byte_q.size() != 0 &&
                     !(byte_q[0].hold && word_counts_q.size() != 0)) begin
          drv_item = byte_q.pop_front();
          in_valid  <= 1'b1;
          data_byte <= drv_item.data;
          last_byte <= drv_item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall the result channel and check each text result
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (word_counts_q.size() == 0) begin
          $display("%0t: unexpected result, word_total %0d text_valid %0b",
                   $time, word_total, text_valid);
          errors++;
        end else begin
          mon_want = word_counts_q.pop_front();
          if (word_total !== mon_want.total) begin
            $display("%0t: word_total mismatch, expected %0d actual %0d",
                     $time, mon_want.total, word_total);
            errors++;
          end
          if (text_valid !== mon_want.ok) begin
            $display("%0t: text_valid mismatch, expected %0b actual %0b",
                     $time, mon_want.ok, text_valid);
            errors++;
          end
        end
      end
      // vary stall pressure over time, none in the final stretch
      mon_cycles++;
      if (mon_cycles % 300 == 0) begin
        case ($urandom_range(0, 3))
          0:       snk_idle_pct = 0;
          1:       snk_idle_pct = 5;
          2:       snk_idle_pct = 20;
          default: snk_idle_pct = 60;
        endcase
      end
      if (stall_left == 0 && byte_q.size() >= TAIL_BYTES &&
          $urandom_range(0, 99) < snk_idle_pct)
        stall_left = $urandom_range(1, 19);
      out_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    int n_texts;
    int n_points;
    clear_text();

    // single ASCII letter
    put(8'h41); end_text();
    // apostrophe inside a word, then one after a space that opens nothing
    put(8'h7A); put(8'h27); put(8'h20); put(8'h27); put(8'h30); end_text();
    // Latin letter continued by a right single quote
    put(8'hC3); put(8'h80); put(8'hE2); put(8'h80); put(8'h99); end_text();
    // lone invalid lead byte
    put(8'hFF); end_text();
    // overlong two-byte form
    put(8'hC0); put(8'h80); end_text();
    // surrogate
    put(8'hED); put(8'hA0); put(8'h80); end_text();
    // above the code point limit
    put(8'hF4); put(8'h90); put(8'h80); put(8'h80); end_text();
    // bad continuation, the byte then opens a word
    put(8'hC3); put(8'h41); end_text();
    // sequence truncated by the end of text
    put(8'hE4); put(8'hB8); end_text();

    n_texts = 0;
    while (byte_q.size() < RANDOM_BYTES + 25) begin
      case ($urandom_range(0, 9))
        0, 1:    n_points = 1;
        8:       n_points = $urandom_range(13, 40);
        9:       n_points = $urandom_range(1, 4);
        default: n_points = $urandom_range(2, 12);
      endcase
      add_text(n_points, ($urandom_range(0, 9) < 3) ? 15 : 0, (n_texts % 25) == 0);
      n_texts++;
    end
    bytes_total = byte_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (bytes_accepted != bytes_total || word_counts_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Give up well past the slowest legal run
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### files.f
rtl/uwc_pkg.sv
rtl/uwc_decode.sv
rtl/uwc_out_buf.sv
rtl/utf8_word_counter_core.sv
sim/tb.sv
